// ===== sv/wua_pkg.sv =====
`timescale 1ns / 1ps

package wua_pkg;

   // Default sizing of the history and of the core lanes
   localparam int HISTORY_DEPTH_DEF = 15;
   localparam int MAX_CORES_DEF     = 8;

   // Fixed field widths
   localparam int USAGE_W     = 7;
   localparam int CORE_FIELDS = 8;
   localparam int CSR_W       = 4;
   localparam int QUOT_W      = 7;

   localparam logic [CSR_W-1:0] CORES_RESET = 4'd8;

   // Word kinds on the request channel
   localparam logic KIND_STORE  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Controller states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } wua_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic store;
      logic clear;
      logic rd_en;
      logic div_load;
      logic div_step;
      logic load_out;
   } wua_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic count_zero;
      logic rd_last;
      logic out_free;
   } wua_sts_type;

endpackage

// ===== sv/wua_req_if.sv =====
`timescale 1ns / 1ps

interface wua_req_if import wua_pkg::*;;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [USAGE_W-1:0] general_usage;
   logic [USAGE_W-1:0] core0_usage;
   logic [USAGE_W-1:0] core1_usage;
   logic [USAGE_W-1:0] core2_usage;
   logic [USAGE_W-1:0] core3_usage;
   logic [USAGE_W-1:0] core4_usage;
   logic [USAGE_W-1:0] core5_usage;
   logic [USAGE_W-1:0] core6_usage;
   logic [USAGE_W-1:0] core7_usage;

   modport source (
      output valid, kind, general_usage, core0_usage, core1_usage, core2_usage,
             core3_usage, core4_usage, core5_usage, core6_usage, core7_usage,
      input  ready
   );

   modport sink (
      input  valid, kind, general_usage, core0_usage, core1_usage, core2_usage,
             core3_usage, core4_usage, core5_usage, core6_usage, core7_usage,
      output ready
   );
endinterface

// ===== sv/wua_rsp_if.sv =====
`timescale 1ns / 1ps

interface wua_rsp_if import wua_pkg::*;;
   logic               valid;
   logic               ready;
   logic [USAGE_W-1:0] avg_general;
   logic [USAGE_W-1:0] avg_core0;
   logic [USAGE_W-1:0] avg_core1;
   logic [USAGE_W-1:0] avg_core2;
   logic [USAGE_W-1:0] avg_core3;
   logic [USAGE_W-1:0] avg_core4;
   logic [USAGE_W-1:0] avg_core5;
   logic [USAGE_W-1:0] avg_core6;
   logic [USAGE_W-1:0] avg_core7;

   modport source (
      output valid, avg_general, avg_core0, avg_core1, avg_core2, avg_core3,
             avg_core4, avg_core5, avg_core6, avg_core7,
      input  ready
   );

   modport sink (
      input  valid, avg_general, avg_core0, avg_core1, avg_core2, avg_core3,
             avg_core4, avg_core5, avg_core6, avg_core7,
      output ready
   );
endinterface

// ===== sv/wua_ram.sv =====
`timescale 1ns / 1ps

module wua_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/wua_datapath.sv =====
`timescale 1ns / 1ps

module wua_datapath import wua_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int MAX_CORES     = MAX_CORES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  wua_cmd_type        cmd,
   output wua_sts_type        sts,
   input  logic               csr_we,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  logic [USAGE_W-1:0] in_general,
   input  logic [USAGE_W-1:0] in_core [CORE_FIELDS],
   input  logic               out_ready,
   output logic               out_valid,
   output logic [USAGE_W-1:0] out_general,
   output logic [USAGE_W-1:0] out_core [CORE_FIELDS]
);

   localparam int LANES = MAX_CORES + 1;
   localparam int AW    = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW    = $clog2(HISTORY_DEPTH + 1);
   localparam int SW    = USAGE_W + CW;
   localparam int DW    = SW + 2;
   localparam int MEM_W = USAGE_W * LANES;

   logic [CSR_W-1:0]   cores_ff;
   logic [CSR_W-1:0]   lanes_used;
   logic [CW-1:0]      count_ff;
   logic [AW-1:0]      slot_ff;
   logic [AW-1:0]      idx_ff;
   logic               pend_ff;
   logic               out_valid_ff;
   logic [MEM_W-1:0]   wr_data;
   logic [MEM_W-1:0]   rd_data;
   logic [DW-1:0]      dv_ff;
   logic [SW-1:0]      sum_ff  [LANES];
   logic [DW-1:0]      rem_ff  [LANES];
   logic [QUOT_W-1:0]  quot_ff [LANES];
   logic [USAGE_W-1:0] out_general_ff;
   logic [USAGE_W-1:0] out_core_ff [CORE_FIELDS];

   // Hold the lane-count register
   always_ff @(posedge clock) begin
      if (reset) begin
         cores_ff <= CORES_RESET;
      end else if (csr_we) begin
         cores_ff <= csr_wdata;
      end
   end

   // Saturate the lane count at the number of built lanes
   assign lanes_used = (cores_ff > CSR_W'(MAX_CORES)) ? CSR_W'(MAX_CORES) : cores_ff;

   // Pack one sample into a history word
   always_comb begin
      wr_data = '0;
      wr_data[USAGE_W-1:0] = in_general;
      for (int k = 0; k < MAX_CORES; k++) begin
         wr_data[(k + 1) * USAGE_W +: USAGE_W] = in_core[k];
      end
   end

   wua_ram #(
      .WIDTH (MEM_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_wua_ram (
      .clock (clock),
      .we    (cmd.store),
      .waddr (slot_ff),
      .wdata (wr_data),
      .re    (cmd.rd_en),
      .raddr (idx_ff),
      .rdata (rd_data)
   );

   // Advance write slot and fill count, sweep the read index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         slot_ff  <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= cmd.rd_en;
         if (cmd.store) begin
            slot_ff <= (slot_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + AW'(1);
            if (count_ff != CW'(HISTORY_DEPTH)) begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cmd.clear) begin
            idx_ff <= '0;
         end else if (cmd.rd_en) begin
            idx_ff <= idx_ff + AW'(1);
         end
      end
   end

   // Shift the divisor down one place per quotient bit
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dv_ff <= DW'(count_ff) << QUOT_W;
      end else if (cmd.div_step) begin
         dv_ff <= dv_ff >> 1;
      end
   end

   // Per lane: accumulate, then divide by restoring steps
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      always_ff @(posedge clock) begin
         if (cmd.clear) begin
            sum_ff[l] <= '0;
         end else if (pend_ff) begin
            sum_ff[l] <= sum_ff[l] + SW'(rd_data[l * USAGE_W +: USAGE_W]);
         end
         if (cmd.div_load) begin
            rem_ff[l]  <= DW'({sum_ff[l], 1'b0}) + DW'(count_ff);
            quot_ff[l] <= '0;
         end else if (cmd.div_step) begin
            if (rem_ff[l] >= dv_ff) begin
               rem_ff[l]  <= rem_ff[l] - dv_ff;
               quot_ff[l] <= {quot_ff[l][QUOT_W-2:0], 1'b1};
            end else begin
               quot_ff[l] <= {quot_ff[l][QUOT_W-2:0], 1'b0};
            end
         end
      end
   end

   // Hold the result word until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_general_ff <= quot_ff[0];
      end
   end

   // Drop the lanes that are not in use
   for (genvar k = 0; k < CORE_FIELDS; k++) begin : g_out
      if (k < MAX_CORES) begin : g_built
         always_ff @(posedge clock) begin
            if (cmd.load_out) begin
               out_core_ff[k] <= (CSR_W'(k) < lanes_used) ? quot_ff[k + 1] : '0;
            end
         end
      end else begin : g_absent
         always_ff @(posedge clock) begin
            if (cmd.load_out) begin
               out_core_ff[k] <= '0;
            end
         end
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_general  = out_general_ff;
   assign out_core     = out_core_ff;

   assign sts.count_zero = (count_ff == '0);
   assign sts.rd_last    = (CW'(idx_ff) == count_ff - CW'(1));
   assign sts.out_free   = !out_valid_ff || out_ready;

endmodule

// ===== sv/wua_ctrl.sv =====
`timescale 1ns / 1ps

module wua_ctrl import wua_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_kind,
   output logic        req_ready,
   input  wua_sts_type sts,
   output wua_cmd_type cmd
);

   localparam int DCW = $clog2(QUOT_W);

   wua_state_type  state_ff, state_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // Sequence store, sweep, divide and hand-off
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_STORE) begin
                  cmd.store = 1'b1;
               end else if (!sts.count_zero) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            if (sts.rd_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DCW'(QUOT_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/windowed_usage_average.sv =====
`timescale 1ns / 1ps
// Store word: accepted while idle; the next word may follow in the cycle after.
// Report word with N stored samples: a history sweep of N memory reads, a drain and
// a divider load, then a 7-step restoring division in every lane on a shared divisor;
// the result is registered on leaving ST_DONE, and only then is the next word taken.
// Report on an empty history: taken while idle, no result.
// Reset (synchronous, active high): history empty, lane count 8, no result pending.

module windowed_usage_average import wua_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int MAX_CORES     = MAX_CORES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   wua_req_if.sink           req_chan,
   wua_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_wdata
);

   wua_cmd_type        cmd;
   wua_sts_type        sts;
   logic [USAGE_W-1:0] in_core  [CORE_FIELDS];
   logic [USAGE_W-1:0] out_core [CORE_FIELDS];

   assign in_core[0] = req_chan.core0_usage;
   assign in_core[1] = req_chan.core1_usage;
   assign in_core[2] = req_chan.core2_usage;
   assign in_core[3] = req_chan.core3_usage;
   assign in_core[4] = req_chan.core4_usage;
   assign in_core[5] = req_chan.core5_usage;
   assign in_core[6] = req_chan.core6_usage;
   assign in_core[7] = req_chan.core7_usage;

   wua_ctrl u_wua_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wua_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .MAX_CORES     (MAX_CORES)
   ) u_wua_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .in_general  (req_chan.general_usage),
      .in_core     (in_core),
      .out_ready   (rsp_chan.ready),
      .out_valid   (rsp_chan.valid),
      .out_general (rsp_chan.avg_general),
      .out_core    (out_core)
   );

   assign rsp_chan.avg_core0 = out_core[0];
   assign rsp_chan.avg_core1 = out_core[1];
   assign rsp_chan.avg_core2 = out_core[2];
   assign rsp_chan.avg_core3 = out_core[3];
   assign rsp_chan.avg_core4 = out_core[4];
   assign rsp_chan.avg_core5 = out_core[5];
   assign rsp_chan.avg_core6 = out_core[6];
   assign rsp_chan.avg_core7 = out_core[7];

endmodule

// ===== sv/wua_checker.sv =====
`timescale 1ns / 1ps

module wua_checker import wua_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [USAGE_W-1:0] avg_core7,
   input logic               csr_we,
   input logic [CSR_W-1:0]   csr_wdata
);

   logic [CSR_W-1:0] cores_ff;
   logic             seen_store_ff;

   // Track the lane count and whether any sample was stored
   always_ff @(posedge clock) begin
      if (reset) begin
         cores_ff      <= CORES_RESET;
         seen_store_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cores_ff <= csr_wdata;
         end
         if (req_valid && req_ready && req_kind == KIND_STORE) begin
            seen_store_ff <= 1'b1;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_no_result_unfilled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_store_ff)
      else $error("result word without any stored sample");

   a_unused_lane_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cores_ff < CSR_W'(CORE_FIELDS) |-> avg_core7 == '0)
      else $error("unused core lane not zero");

endmodule

bind windowed_usage_average wua_checker u_wua_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_kind  (req_chan.kind),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .avg_core7 (rsp_chan.avg_core7),
   .csr_we    (csr_we),
   .csr_wdata (csr_wdata)
);
